/* design/fkhp_pkg.sv */
// ----------------------------------------------------------------------------
// fkhp_pkg
// types and constants shared by the flow key header parser modules
// ----------------------------------------------------------------------------
package fkhp_pkg;

	// one packet byte as it arrives on the wire
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
		logic [7:0] ingress_port;
	} pkt_item_t;

	// one assembled flow key
	typedef struct packed {
		logic [7:0]  port_out;
		logic [47:0] mac_dst;
		logic [47:0] mac_src;
		logic [15:0] eth_kind;
		logic [14:0] vlan_info;
		logic [31:0] ipv4_src;
		logic [31:0] ipv4_dst;
		logic [23:0] proto_tos_ttl;
		logic [1:0]  frag_kind;
		logic [31:0] l4_ports;
		logic        truncated;
	} key_item_t;

	// parser state carried from byte to byte
	typedef struct packed {
		logic [5:0]  byte_offset;
		logic        tag_seen;
		logic [7:0]  held_port;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [15:0] eth_type;
		logic [14:0] tag_info;
		logic [31:0] ip_src;
		logic [31:0] ip_dst;
		logic [23:0] ip_misc;
		logic [13:0] frag_word;
		logic [31:0] ports;
	} parse_state_t;

	localparam logic [15:0] TYPE_VLAN  = 16'h8100;
	localparam logic [15:0] TYPE_IPV4  = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;

	localparam logic [5:0] OFFSET_MAX   = 6'd63;
	localparam logic [5:0] ETH_LEN      = 6'd14;
	localparam logic [5:0] TAG_LEN      = 6'd4;
	localparam logic [5:0] IPV4_LEN     = 6'd20;
	localparam logic [5:0] L4_PORTS_LEN = 6'd4;
	localparam logic [5:0] ICMP_LEN     = 6'd2;

	localparam logic [1:0] FRAG_NONE  = 2'd0;
	localparam logic [1:0] FRAG_FIRST = 2'd1;
	localparam logic [1:0] FRAG_LATER = 2'd2;

endpackage

/* design/fkhp_lane_update.sv */
// ----------------------------------------------------------------------------
// fkhp_lane_update
// places one packet byte into its byte lane of the parser state
// ----------------------------------------------------------------------------
module fkhp_lane_update (
	input  fkhp_pkg::parse_state_t cur,
	input  fkhp_pkg::pkt_item_t    item,
	output fkhp_pkg::parse_state_t upd,
	output logic [5:0]             off
);
	import fkhp_pkg::*;

	// byte positions in the ethernet header and tag
	localparam logic [5:0] SRC_START = 6'd6;
	localparam logic [5:0] TYPE_HI   = 6'd12;
	localparam logic [5:0] TYPE_LO   = 6'd13;
	localparam logic [5:0] TCI_HI    = 6'd14;
	localparam logic [5:0] TCI_LO    = 6'd15;
	localparam logic [5:0] ITYPE_HI  = 6'd16;
	localparam logic [5:0] TAG_END   = 6'd18;

	// byte positions inside the ipv4 header
	localparam logic [5:0] IP_TOS     = 6'd1;
	localparam logic [5:0] IP_FRAG_HI = 6'd6;
	localparam logic [5:0] IP_FRAG_LO = 6'd7;
	localparam logic [5:0] IP_TTL     = 6'd8;
	localparam logic [5:0] IP_L4_TYPE = 6'd9;

	parse_state_t s;
	logic [7:0]   b;
	logic [5:0]   base;
	logic [5:0]   r;
	logic [5:0]   q;
	logic [7:0]   proto;
	logic         later;

	always_comb begin
		s = cur;
		if (item.first_byte) begin
			s = '0;
			s.held_port = item.ingress_port;
		end
		b     = item.data_byte;
		off   = s.byte_offset;
		base  = s.tag_seen ? (ETH_LEN + TAG_LEN) : ETH_LEN;
		r     = off - base;
		q     = r - IPV4_LEN;
		proto = s.ip_misc[23:16];
		later = (s.frag_word[12:0] != '0);

		if (off < SRC_START) begin
			s.dst_mac[{3'(3'd5 - off[2:0]), 3'b000} +: 8] = b;
		end else if (off < TYPE_HI) begin
			s.src_mac[{3'(4'd11 - off[3:0]), 3'b000} +: 8] = b;
		end else if (off == TYPE_HI) begin
			s.eth_type[15:8] = b;
		end else if (off == TYPE_LO) begin
			s.eth_type[7:0] = b;
			s.tag_seen      = ({s.eth_type[15:8], b} == TYPE_VLAN);
		end else if (s.tag_seen && off < TAG_END) begin
			case (off)
				TCI_HI: begin
					// priority from tci 15:13, id high nibble from 11:8, cfi dropped
					s.tag_info[14:12] = b[7:5];
					s.tag_info[11:8]  = b[3:0];
				end
				TCI_LO:   s.tag_info[7:0]  = b;
				ITYPE_HI: s.eth_type[15:8] = b;
				default:  s.eth_type[7:0]  = b;
			endcase
		end else if (s.eth_type == TYPE_IPV4) begin
			if (r < IPV4_LEN) begin
				case (r)
					IP_TOS:     s.ip_misc[15:8]    = b;
					IP_FRAG_HI: s.frag_word[13:8]  = b[5:0];
					IP_FRAG_LO: s.frag_word[7:0]   = b;
					IP_TTL:     s.ip_misc[7:0]     = b;
					IP_L4_TYPE: s.ip_misc[23:16]   = b;
					default: begin
						if (r inside {[6'd12:6'd15]}) begin
							s.ip_src[{~r[1:0], 3'b000} +: 8] = b;
						end else if (r inside {[6'd16:6'd19]}) begin
							s.ip_dst[{~r[1:0], 3'b000} +: 8] = b;
						end
					end
				endcase
			end else if (!later) begin
				if ((proto == PROTO_TCP || proto == PROTO_UDP) && q < L4_PORTS_LEN) begin
					s.ports[{~q[1:0], 3'b000} +: 8] = b;
				end else if (proto == PROTO_ICMP && q == 6'd0) begin
					s.ports[23:16] = b;
				end else if (proto == PROTO_ICMP && q == 6'd1) begin
					s.ports[7:0] = b;
				end
			end
		end
		upd = s;
	end

endmodule

/* design/fkhp_key_build.sv */
// ----------------------------------------------------------------------------
// fkhp_key_build
// forms the flow key and the parser state for the following byte
// ----------------------------------------------------------------------------
module fkhp_key_build (
	input  fkhp_pkg::parse_state_t upd,
	input  logic [5:0]             off,
	input  logic                   last,
	output fkhp_pkg::key_item_t    key,
	output fkhp_pkg::parse_state_t nxt
);
	import fkhp_pkg::*;

	logic [6:0] count;
	logic [5:0] need;
	logic       later;
	logic [7:0] proto;

	always_comb begin
		count = {1'b0, off} + 7'd1;
		later = (upd.frag_word[12:0] != '0);
		proto = upd.ip_misc[23:16];

		// bytes required before the packet may end
		need = upd.tag_seen ? (ETH_LEN + TAG_LEN) : ETH_LEN;
		if (count >= {1'b0, need} && upd.eth_type == TYPE_IPV4) begin
			need = need + IPV4_LEN;
			if (count >= {1'b0, need} && !later) begin
				if (proto == PROTO_TCP || proto == PROTO_UDP) begin
					need = need + L4_PORTS_LEN;
				end else if (proto == PROTO_ICMP) begin
					need = need + ICMP_LEN;
				end
			end
		end

		key.port_out      = upd.held_port;
		key.mac_dst       = upd.dst_mac;
		key.mac_src       = upd.src_mac;
		key.eth_kind      = upd.eth_type;
		key.vlan_info     = upd.tag_info;
		key.ipv4_src      = upd.ip_src;
		key.ipv4_dst      = upd.ip_dst;
		key.proto_tos_ttl = upd.ip_misc;
		key.frag_kind     = later ? FRAG_LATER : (upd.frag_word[13] ? FRAG_FIRST : FRAG_NONE);
		key.l4_ports      = upd.ports;
		key.truncated     = (count < {1'b0, need});

		if (last) begin
			nxt           = '0;
			nxt.held_port = upd.held_port;
		end else begin
			nxt             = upd;
			nxt.byte_offset = (off == OFFSET_MAX) ? off : off + 6'd1;
		end
	end

endmodule

/* design/flow_key_header_parser_unit.sv */
// ----------------------------------------------------------------------------
// flow_key_header_parser_unit
// ethernet / 802.1q / ipv4 / l4 header parser building one flow key a packet
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------
//  pkt     | in  | pkt_valid / pkt_ready  | one packet byte and its marks
//  key     | out | key_valid / key_ready  | flow key, one per packet
//
//  one item per clock sustained unless a last byte waits on an unread key; a key
//  passes the input register, then the lane update into the key register
//  the parser state is updated once per byte in a single pass, so bytes of
//  one packet may follow each other in consecutive cycles
//  arst_n clears the parser state, the held port and both valid flags
//  a stalled key only holds back the pipe when the next byte is a last byte;
//  other bytes keep moving since they produce no key
//
module flow_key_header_parser_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pkt_valid,
	output logic                pkt_ready,
	input  fkhp_pkg::pkt_item_t pkt,
	output logic                key_valid,
	input  logic                key_ready,
	output fkhp_pkg::key_item_t key
);
	import fkhp_pkg::*;

	// input register
	logic         item_valid_s1;
	pkt_item_t    item_s1;

	// parser state across bytes of a packet
	parse_state_t state_q;

	// single pass update
	parse_state_t upd;
	parse_state_t nxt;
	logic [5:0]   off;
	key_item_t    key_d;
	logic         advance;

	// result register
	logic         key_valid_q;
	key_item_t    key_q;

	// a byte moves on unless it would make a key while the result register holds an untaken key
	assign advance   = item_valid_s1 && (!item_s1.last_byte || !key_valid_q || key_ready);
	assign pkt_ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (pkt_ready) begin
			item_valid_s1 <= pkt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_valid && pkt_ready) begin
			item_s1 <= pkt;
		end
	end

	fkhp_lane_update u_lane_update (
		.cur  (state_q),
		.item (item_s1),
		.upd  (upd),
		.off  (off)
	);

	fkhp_key_build u_key_build (
		.upd  (upd),
		.off  (off),
		.last (item_s1.last_byte),
		.key  (key_d),
		.nxt  (nxt)
	);

	// parser state, all fields start at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			key_valid_q <= 1'b1;
		end else if (key_ready) begin
			key_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			key_q <= key_d;
		end
	end

	assign key_valid = key_valid_q;
	assign key       = key_q;

	// ipv4 fields only fill in under an ipv4 ethertype
	a_non_ipv4_zero : assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key.eth_kind != TYPE_IPV4 |->
			key.ipv4_src == '0 && key.ipv4_dst == '0 &&
			key.proto_tos_ttl == '0 && key.l4_ports == '0)
		else $error("ipv4 fields set in a non ipv4 key");

	// later fragments carry no l4 header
	a_later_frag_ports : assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key.frag_kind == FRAG_LATER |-> key.l4_ports == '0)
		else $error("ports set in a later fragment key");

	// the offset restarts after every last byte
	a_offset_restart : assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.last_byte |=> state_q.byte_offset == '0 && !state_q.tag_seen)
		else $error("parser state not cleared after last byte");

	// a pending key is never overwritten by the next one
	a_no_key_overrun : assert property (@(posedge clk) disable iff (!arst_n)
		key_valid_q && !key_ready |-> !(advance && item_s1.last_byte))
		else $error("key register overwritten while stalled");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the flow key header parser: packets are queued
// byte by byte, a local parser predicts each flow key, and every key taken
// from the block is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb;

	import fkhp_pkg::*;

	// content used to pre-fill a frame before its header fields are placed
	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off at a phase start
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item accepted on either side
	localparam int PHASE_BYTES    = 500;   // random bytes queued in each phase
	localparam int DRAIN_CYCLES   = 8;     // margin left for the last key to leave the block

	logic      clk;
	logic      arst_n = 1'b0;
	logic      pkt_valid = 1'b0;
	logic      pkt_ready;
	pkt_item_t pkt = '0;
	logic      key_valid;
	logic      key_ready = 1'b0;
	key_item_t key;

	flow_key_header_parser_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt),
		.key_valid (key_valid),
		.key_ready (key_ready),
		.key       (key)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// bytes waiting to be offered, and flow keys predicted but not yet seen
	pkt_item_t wire_bytes [$];
	key_item_t expected_keys [$];

	int errors = 0;
	int queued_bytes = 0;
	int idle_cycles = 0;
	bit pkt_fire = 1'b0;

	// idling percentages for the current phase
	int phase = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_phase = -1;
	int hold_left = 0;

	// local copy of the parser state
	logic [5:0]  cur_offset;
	logic        cur_tagged;
	logic [7:0]  cur_port;
	logic [47:0] cur_dst_mac;
	logic [47:0] cur_src_mac;
	logic [15:0] cur_type;
	logic [14:0] cur_tci;
	logic [31:0] cur_ip_src;
	logic [31:0] cur_ip_dst;
	logic [23:0] cur_ip_misc;
	logic [15:0] cur_frag;
	logic [31:0] cur_ports;

	task automatic report(input string msg);
		$display("%s", msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [47:0] got,
			input logic [47:0] want);
		if (got !== want) begin
			report($sformatf("tb: %s mismatch, got %0h want %0h", name, got, want));
		end
	endtask

	function automatic void clear_flow();
		cur_offset  = '0;
		cur_tagged  = 1'b0;
		cur_dst_mac = '0;
		cur_src_mac = '0;
		cur_type    = '0;
		cur_tci     = '0;
		cur_ip_src  = '0;
		cur_ip_dst  = '0;
		cur_ip_misc = '0;
		cur_frag    = '0;
		cur_ports   = '0;
	endfunction

	// nonzero fragment offset means this is not the first fragment
	function automatic bit later_fragment();
		return cur_frag[12:0] != 13'd0;
	endfunction

	// place one byte into the lane it belongs to, by offset and header kind
	function automatic void place_byte(input int off, input logic [7:0] b);
		int r;
		logic [7:0] proto;
		if (off < 6) begin
			cur_dst_mac[(5 - off) * 8 +: 8] = b;
		end else if (off < 12) begin
			cur_src_mac[(11 - off) * 8 +: 8] = b;
		end else if (off == 12) begin
			cur_type[15:8] = b;
		end else if (off == 13) begin
			cur_type[7:0] = b;
			cur_tagged = (cur_type == TYPE_VLAN);
		end else if (cur_tagged && off < 18) begin
			case (off)
				14: begin
					// priority from the top three bits, tci bit 12 dropped
					cur_tci[14:12] = b[7:5];
					cur_tci[11:8]  = b[3:0];
				end
				15: cur_tci[7:0] = b;
				16: cur_type[15:8] = b;
				default: cur_type[7:0] = b;
			endcase
		end else if (cur_type == TYPE_IPV4) begin
			r = off - (cur_tagged ? 18 : 14);
			if (r < 20) begin
				case (r)
					1: cur_ip_misc[15:8] = b;
					6: cur_frag[15:8] = b;
					7: cur_frag[7:0] = b;
					8: cur_ip_misc[7:0] = b;
					9: cur_ip_misc[23:16] = b;
					default: begin
						if (r >= 12 && r < 16) begin
							cur_ip_src[(15 - r) * 8 +: 8] = b;
						end else if (r >= 16) begin
							cur_ip_dst[(19 - r) * 8 +: 8] = b;
						end
					end
				endcase
			end else if (!later_fragment()) begin
				r -= 20;
				proto = cur_ip_misc[23:16];
				if ((proto == PROTO_TCP || proto == PROTO_UDP) && r < 4) begin
					cur_ports[(3 - r) * 8 +: 8] = b;
				end else if (proto == PROTO_ICMP && r == 0) begin
					cur_ports[23:16] = b;
				end else if (proto == PROTO_ICMP && r == 1) begin
					cur_ports[7:0] = b;
				end
			end
		end
	endfunction

	function automatic bit header_short(input int count);
		int need;
		logic [7:0] proto;
		need = cur_tagged ? 18 : 14;
		proto = cur_ip_misc[23:16];
		if (count >= need && cur_type == TYPE_IPV4) begin
			need += 20;
			if (count >= need && !later_fragment()) begin
				if (proto == PROTO_TCP || proto == PROTO_UDP) begin
					need += 4;
				end else if (proto == PROTO_ICMP) begin
					need += 2;
				end
			end
		end
		return count < need;
	endfunction

	// advance the local parser by one accepted byte, predicting a key on a last byte
	function automatic void parse_byte(input pkt_item_t it);
		int off;
		key_item_t k;
		if (it.first_byte) begin
			clear_flow();
			cur_port = it.ingress_port;
		end
		off = cur_offset;
		place_byte(off, it.data_byte);
		if (it.last_byte) begin
			k.port_out      = cur_port;
			k.mac_dst       = cur_dst_mac;
			k.mac_src       = cur_src_mac;
			k.eth_kind      = cur_type;
			k.vlan_info     = cur_tci;
			k.ipv4_src      = cur_ip_src;
			k.ipv4_dst      = cur_ip_dst;
			k.proto_tos_ttl = cur_ip_misc;
			k.frag_kind     = later_fragment() ? FRAG_LATER :
				(cur_frag[13] ? FRAG_FIRST : FRAG_NONE);
			k.l4_ports      = cur_ports;
			k.truncated     = header_short(off + 1);
			expected_keys.push_back(k);
			clear_flow();
		end else begin
			cur_offset = (off < OFFSET_MAX) ? 6'(off + 1) : OFFSET_MAX;
		end
	endfunction

	task automatic check_key(input key_item_t got);
		key_item_t want;
		if (expected_keys.size() == 0) begin
			report("tb: key taken with no packet end pending");
		end else begin
			want = expected_keys.pop_front();
			check_field("port_out", got.port_out, want.port_out);
			check_field("mac_dst", got.mac_dst, want.mac_dst);
			check_field("mac_src", got.mac_src, want.mac_src);
			check_field("eth_kind", got.eth_kind, want.eth_kind);
			check_field("vlan_info", got.vlan_info, want.vlan_info);
			check_field("ipv4_src", got.ipv4_src, want.ipv4_src);
			check_field("ipv4_dst", got.ipv4_dst, want.ipv4_dst);
			check_field("proto_tos_ttl", got.proto_tos_ttl, want.proto_tos_ttl);
			check_field("frag_kind", got.frag_kind, want.frag_kind);
			check_field("l4_ports", got.l4_ports, want.l4_ports);
			check_field("truncated", got.truncated, want.truncated);
		end
	endtask

	// build a frame, place the header fields that steer parsing, queue len bytes
	task automatic push_packet(input bit mark_first, input bit mark_last, input int len,
			input logic [7:0] port, input bit vlan_tag, input logic [15:0] etype,
			input logic [7:0] proto, input logic [15:0] fragw, input fill_t fill);
		logic [7:0] frame [0:79];
		pkt_item_t it;
		int h;
		for (int i = 0; i < 80; i++) begin
			frame[i] = (fill == FILL_ZERO) ? 8'h00 :
				(fill == FILL_ONES) ? 8'hFF : 8'($urandom);
		end
		if (vlan_tag) begin
			frame[12] = TYPE_VLAN[15:8];
			frame[13] = TYPE_VLAN[7:0];
		end
		h = vlan_tag ? 16 : 12;
		frame[h]      = etype[15:8];
		frame[h + 1]  = etype[7:0];
		frame[h + 8]  = fragw[15:8];
		frame[h + 9]  = fragw[7:0];
		frame[h + 11] = proto;
		for (int i = 0; i < len; i++) begin
			it.data_byte    = (i < 80) ? frame[i] : 8'($urandom);
			it.first_byte   = (i == 0) && mark_first;
			it.last_byte    = (i == len - 1) && mark_last;
			it.ingress_port = (i == 0) ? port : 8'($urandom);
			wire_bytes.push_back(it);
		end
		queued_bytes += len;
	endtask

	// mostly well-formed ipv4 packets with random content, some noise mixed in
	task automatic random_packet(input bit allow_noise);
		bit vlan_tag;
		bit first_m;
		bit last_m;
		logic [15:0] etype;
		logic [15:0] fragw;
		logic [7:0] proto;
		int hdr;
		int len;
		int sel;
		vlan_tag = ($urandom_range(9) < 3);
		etype = TYPE_IPV4;
		case ($urandom_range(3))
			0: proto = PROTO_TCP;
			1: proto = PROTO_UDP;
			2: proto = PROTO_ICMP;
			default: proto = 8'($urandom);
		endcase
		sel = $urandom_range(9);
		fragw = 16'($urandom);
		if (sel < 6) begin
			fragw[13:0] = '0;
		end else if (sel < 8) begin
			fragw[13] = 1'b1;
			fragw[12:0] = '0;
		end else if (fragw[12:0] == 13'd0) begin
			fragw[0] = 1'b1;
		end
		hdr = (vlan_tag ? 18 : 14) + 20 + ((proto == PROTO_ICMP) ? 2 : 4);
		len = hdr + $urandom_range(0, 6);
		first_m = 1'b1;
		last_m = 1'b1;
		if (allow_noise && $urandom_range(99) < 25) begin
			case ($urandom_range(6))
				0: begin
					etype = 16'($urandom);
					if (etype == TYPE_VLAN) begin
						etype = 16'h86DD;
					end
				end
				1: begin
					vlan_tag = 1'b1;
					etype = TYPE_VLAN;
				end
				2: len = $urandom_range(1, hdr - 1);
				3: first_m = 1'b0;
				4: len = $urandom_range(64, 80);
				5: last_m = 1'b0;
				default: len = 1;
			endcase
		end
		push_packet(first_m, last_m, len, 8'($urandom), vlan_tag, etype, proto, fragw,
			FILL_RANDOM);
	endtask

	// sender: a held item stays until taken, otherwise offer the next one or idle
	always @(negedge clk) begin
		if (arst_n) begin
			if (!pkt_valid || pkt_fire) begin
				if (wire_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
					pkt_valid <= 1'b1;
					pkt <= wire_bytes.pop_front();
				end else begin
					pkt_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: long hold-off at each phase start so the block backs up,
	// random stalls afterwards
	always @(negedge clk) begin
		if (arst_n) begin
			if (phase != hold_phase) begin
				hold_phase <= phase;
				hold_left <= HOLD_CYCLES;
				key_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				key_ready <= 1'b0;
			end else begin
				key_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// monitor: the key check runs before the byte is parsed, so a key leaving
	// in the same cycle as a last byte arrives is matched against older ones
	always @(posedge clk) begin
		pkt_fire <= pkt_valid && pkt_ready;
		if (arst_n) begin
			if (key_valid && key_ready) begin
				check_key(key);
			end
			if (pkt_valid && pkt_ready) begin
				parse_byte(pkt);
			end
			if ((key_valid && key_ready) || (pkt_valid && pkt_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		cur_port = '0;
		clear_flow();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase 0: sender idles 35 in 100, receiver 67 in 100
		phase = 0;
		send_idle = 35;
		recv_idle = 67;

		// lone unmarked byte right after reset, uses the reset port
		push_packet(1'b0, 1'b1, 1, 8'h00, 1'b0, TYPE_IPV4, PROTO_TCP, 16'h0000, FILL_RANDOM);
		// one-byte packet, first and last together
		push_packet(1'b1, 1'b1, 1, 8'hFF, 1'b0, TYPE_IPV4, PROTO_TCP, 16'h0000, FILL_ONES);
		// tagged tcp, all ones content
		push_packet(1'b1, 1'b1, 42, 8'hFF, 1'b1, TYPE_IPV4, PROTO_TCP, 16'h0000, FILL_ONES);
		// untagged udp, all zero content
		push_packet(1'b1, 1'b1, 38, 8'h00, 1'b0, TYPE_IPV4, PROTO_UDP, 16'h0000, FILL_ZERO);
		// icmp with payload, then icmp cut after its type byte
		push_packet(1'b1, 1'b1, 40, 8'h5A, 1'b0, TYPE_IPV4, PROTO_ICMP, 16'h4000, FILL_RANDOM);
		push_packet(1'b1, 1'b1, 35, 8'hA5, 1'b0, TYPE_IPV4, PROTO_ICMP, 16'h0000, FILL_RANDOM);
		// later fragment keeps its ports at zero
		push_packet(1'b1, 1'b1, 40, 8'h11, 1'b0, TYPE_IPV4, PROTO_TCP, 16'h00B9, FILL_RANDOM);
		// first fragment, more-fragments bit only
		push_packet(1'b1, 1'b1, 44, 8'h22, 1'b1, TYPE_IPV4, PROTO_UDP, 16'h2000, FILL_RANDOM);
		// double tag: inner ethertype is another tag, not ipv4
		push_packet(1'b1, 1'b1, 50, 8'h33, 1'b1, TYPE_VLAN, PROTO_TCP, 16'h0000, FILL_RANDOM);
		// non-ipv4 ethertype
		push_packet(1'b1, 1'b1, 30, 8'h44, 1'b0, 16'h86DD, PROTO_TCP, 16'h0000, FILL_RANDOM);
		// tagged packet ending inside the ip header
		push_packet(1'b1, 1'b1, 25, 8'h55, 1'b1, TYPE_IPV4, PROTO_TCP, 16'h0000, FILL_RANDOM);
		// long packet past the offset saturation point
		push_packet(1'b1, 1'b1, 80, 8'h66, 1'b0, TYPE_IPV4, PROTO_UDP, 16'h0000, FILL_RANDOM);
		// abandoned packet with no last byte, restarted by a first byte
		push_packet(1'b1, 1'b0, 20, 8'h77, 1'b0, TYPE_IPV4, PROTO_TCP, 16'h0000, FILL_RANDOM);
		push_packet(1'b1, 1'b1, 38, 8'h88, 1'b0, TYPE_IPV4, PROTO_TCP, 16'h0000, FILL_RANDOM);
		// unmarked packet after a last byte, reuses the held port
		push_packet(1'b0, 1'b1, 38, 8'h99, 1'b0, TYPE_IPV4, PROTO_UDP, 16'h0000, FILL_RANDOM);

		for (int p = 0; p < 3; p++) begin
			if (p != 0) begin
				@(posedge clk);
				phase = p;
				send_idle = (p == 1) ? 67 : 0;
				recv_idle = (p == 1) ? 35 : 0;
			end
			queued_bytes = 0;
			while (queued_bytes < PHASE_BYTES) begin
				random_packet(1'b1);
			end
			// close any open packet so every phase ends on a key
			random_packet(1'b0);
			while (wire_bytes.size() != 0) begin
				@(posedge clk);
			end
		end

		while (wire_bytes.size() != 0 || pkt_valid || expected_keys.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_keys.size() != 0) begin
			report("tb: predicted keys never arrived");
		end
		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

/* flow_key_header_parser_unit.f */
design/fkhp_pkg.sv
design/fkhp_lane_update.sv
design/fkhp_key_build.sv
design/flow_key_header_parser_unit.sv
dv/tb.sv
